// ===== rtl/gbn_arq_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_arq_pkg
// Shared types and constants of the go-back-N window block: channel payloads,
// command and result codes, the internal operation and status records.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_arq_pkg;

  localparam int MAX_SEQ     = 7;
  localparam int SEQ_MOD     = MAX_SEQ + 1;
  localparam int SEQ_W       = $clog2(SEQ_MOD);
  localparam int PAYLOAD_W   = 16;
  localparam int CMD_W       = 2;
  localparam int KIND_W      = 2;
  localparam int TIMEOUT_W   = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int OP_W        = 2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd150;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ARRIVE = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SENT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ARRIVAL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESENT  = 2'd3;

  // Operations handed from front to back
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_SEND   = 2'd1;
  localparam logic [OP_W-1:0] OP_ARRIVE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [PAYLOAD_W-1:0] payload_id;
    logic [SEQ_W-1:0]     rx_seq;
    logic [SEQ_W-1:0]     rx_ack;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [SEQ_W-1:0]     tx_seq;
    logic [SEQ_W-1:0]     tx_ack;
    logic [PAYLOAD_W-1:0] tx_payload;
    logic                 delivered;
    logic [SEQ_W-1:0]     outstanding;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [PAYLOAD_W-1:0] payload;
    logic [SEQ_W-1:0]     seq;
    logic [SEQ_W-1:0]     ack;
  } op_t;

  typedef struct packed {
    logic             busy;
    logic [SEQ_W-1:0] count;
    logic [SEQ_W-1:0] oldest;
    logic [SEQ_W-1:0] next;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/gbn_arq_front.sv =====
// ----------------------------------------------------------------------------
// gbn_arq_front
// Input side: accept requests while the queue has room, decode the command
// and drop unknown commands.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_arq_front
  import gbn_arq_pkg::*;
(
  input  wire logic     push,
  input  wire in_item_t in_item,
  output logic          full,
  input  wire logic     q_full,
  output logic          q_push,
  output op_t           q_op
);

  logic known;

  always_comb begin
    known     = 1'b1;
    q_op.op   = OP_TICK;
    unique case (in_item.cmd)
      CMD_TICK:   q_op.op = OP_TICK;
      CMD_SEND:   q_op.op = OP_SEND;
      CMD_ARRIVE: q_op.op = OP_ARRIVE;
      default:    known   = 1'b0;
    endcase
    q_op.payload = in_item.payload_id;
    q_op.seq     = in_item.rx_seq;
    q_op.ack     = in_item.rx_ack;
  end

  // Take an unknown command and drop it.
  assign full   = q_full;
  assign q_push = push && !q_full && known;

endmodule

`default_nettype wire

// ===== rtl/gbn_arq_queue.sv =====
// ----------------------------------------------------------------------------
// gbn_arq_queue
// Short operation queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_arq_queue
  import gbn_arq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_push,
  input  wire op_t  q_op,
  output logic      q_full,
  output logic      q_empty,
  input  wire logic q_pop,
  output op_t       q_head
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  op_t            entry_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign q_full  = (cnt_r == CntW'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_head  = entry_r[rd_ptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= q_op;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gbn_arq_back.sv =====
// ----------------------------------------------------------------------------
// gbn_arq_back
// Window engine: holds sequence state, timers and payload handles, runs one
// operation at a time and feeds the one-deep result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_arq_back
  import gbn_arq_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [TIMEOUT_W-1:0] cfg_data,
  input  wire logic                 q_empty,
  input  wire op_t                  q_head,
  output logic                      q_pop,
  output logic                      empty,
  input  wire logic                 pop,
  output out_item_t                 out_item,
  output status_t                   status
);

  localparam int CmpW = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

  logic [TIMEOUT_W-1:0]  timeout_r;
  logic [SEQ_W-1:0]      oldest_r, oldest_nxt;
  logic [SEQ_W-1:0]      next_r, next_nxt;
  logic [SEQ_W-1:0]      expected_r, expected_nxt;
  logic [SEQ_W-1:0]      count_r, count_nxt;
  logic                  running_r [SEQ_MOD];
  logic                  running_nxt [SEQ_MOD];
  logic [TIMER_BITS-1:0] elapsed_r [SEQ_MOD];
  logic [TIMER_BITS-1:0] elapsed_nxt [SEQ_MOD];
  logic [PAYLOAD_W-1:0]  pay_r [SEQ_MOD];
  logic                  busy_r, busy_nxt;
  logic [SEQ_W-1:0]      rt_seq_r, rt_seq_nxt;
  logic [SEQ_W-1:0]      rt_left_r, rt_left_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r;

  logic                  can_emit, emit;
  out_item_t             emit_item;
  logic                  pay_we;
  logic [CmpW-1:0]       to_ext;
  logic [TIMER_BITS-1:0] limit;
  logic [SEQ_W-1:0]      ack_tx;

  assign to_ext   = CmpW'(timeout_r);
  assign limit    = (to_ext < CmpW'({TIMER_BITS{1'b1}})) ? TIMER_BITS'(to_ext)
                                                         : {TIMER_BITS{1'b1}};
  assign ack_tx   = expected_r - SEQ_W'(1);
  assign can_emit = !out_valid_r || pop;

  always_comb begin
    logic                  expired;
    logic                  hit;
    logic [SEQ_W-1:0]      span;
    logic [SEQ_W-1:0]      off;
    logic [TIMER_BITS-1:0] bumped;

    expired = 1'b0;
    span    = q_head.ack - oldest_r;
    hit     = (count_r != '0) && (span < count_r);
    off     = '0;
    bumped  = '0;

    oldest_nxt   = oldest_r;
    next_nxt     = next_r;
    expected_nxt = expected_r;
    count_nxt    = count_r;
    busy_nxt     = busy_r;
    rt_seq_nxt   = rt_seq_r;
    rt_left_nxt  = rt_left_r;
    for (int i = 0; i < SEQ_MOD; i++) begin
      running_nxt[i] = running_r[i];
      elapsed_nxt[i] = elapsed_r[i];
    end
    q_pop     = 1'b0;
    emit      = 1'b0;
    pay_we    = 1'b0;
    emit_item = '0;

    if (busy_r) begin
      // Resend the window one frame per cycle while the result register can take it, oldest first.
      if (can_emit) begin
        emit                 = 1'b1;
        emit_item.kind       = KIND_RESENT;
        emit_item.tx_seq     = rt_seq_r;
        emit_item.tx_ack     = ack_tx;
        emit_item.tx_payload = pay_r[rt_seq_r];
        emit_item.outstanding = count_r;
        emit_item.last       = (rt_left_r == SEQ_W'(1));
        rt_seq_nxt           = rt_seq_r + SEQ_W'(1);
        rt_left_nxt          = rt_left_r - SEQ_W'(1);
        if (rt_left_r == SEQ_W'(1)) begin
          busy_nxt = 1'b0;
        end
      end
    end else if (!q_empty) begin
      unique case (q_head.op)
        OP_SEND: begin
          if (can_emit) begin
            q_pop = 1'b1;
            emit  = 1'b1;
            if (count_r == SEQ_W'(MAX_SEQ)) begin
              emit_item.kind        = KIND_REFUSED;
              emit_item.outstanding = count_r;
              emit_item.last        = 1'b1;
            end else begin
              pay_we                 = 1'b1;
              running_nxt[next_r]    = 1'b1;
              elapsed_nxt[next_r]    = '0;
              count_nxt              = count_r + SEQ_W'(1);
              next_nxt               = next_r + SEQ_W'(1);
              emit_item.kind         = KIND_SENT;
              emit_item.tx_seq       = next_r;
              emit_item.tx_ack       = ack_tx;
              emit_item.tx_payload   = q_head.payload;
              emit_item.outstanding  = count_r + SEQ_W'(1);
              emit_item.last         = 1'b1;
            end
          end
        end
        OP_ARRIVE: begin
          if (can_emit) begin
            q_pop = 1'b1;
            emit  = 1'b1;
            if (q_head.seq == expected_r) begin
              expected_nxt = expected_r + SEQ_W'(1);
            end
            // When the ack lies in the window, release everything from the oldest up to the acked number.
            for (int i = 0; i < SEQ_MOD; i++) begin
              off = SEQ_W'(i) - oldest_r;
              if (hit && (off <= span)) begin
                running_nxt[i] = 1'b0;
                elapsed_nxt[i] = '0;
              end
            end
            if (hit) begin
              oldest_nxt = q_head.ack + SEQ_W'(1);
              count_nxt  = count_r - span - SEQ_W'(1);
            end
            emit_item.kind        = KIND_ARRIVAL;
            emit_item.delivered   = (q_head.seq == expected_r);
            emit_item.outstanding = hit ? (count_r - span - SEQ_W'(1)) : count_r;
            emit_item.last        = 1'b1;
          end
        end
        OP_TICK: begin
          q_pop = 1'b1;
          for (int i = 0; i < SEQ_MOD; i++) begin
            if (running_r[i]) begin
              bumped = (elapsed_r[i] < limit) ? elapsed_r[i] + TIMER_BITS'(1)
                                              : elapsed_r[i];
              elapsed_nxt[i] = bumped;
              if (bumped >= limit) begin
                expired = 1'b1;
              end
            end
          end
          // On timeout restart every running timer and go back to the oldest.
          if (expired && (count_r != '0)) begin
            busy_nxt    = 1'b1;
            rt_seq_nxt  = oldest_r;
            rt_left_nxt = count_r;
            for (int i = 0; i < SEQ_MOD; i++) begin
              if (running_r[i]) begin
                elapsed_nxt[i] = '0;
              end
            end
          end
        end
        default: q_pop = 1'b1;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      oldest_r    <= '0;
      next_r      <= '0;
      expected_r  <= '0;
      count_r     <= '0;
      busy_r      <= 1'b0;
      rt_seq_r    <= '0;
      rt_left_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SEQ_MOD; i++) begin
        running_r[i] <= 1'b0;
        elapsed_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_data;
      end
      oldest_r    <= oldest_nxt;
      next_r      <= next_nxt;
      expected_r  <= expected_nxt;
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      rt_seq_r    <= rt_seq_nxt;
      rt_left_r   <= rt_left_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < SEQ_MOD; i++) begin
        running_r[i] <= running_nxt[i];
        elapsed_r[i] <= elapsed_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= emit_item;
    end
    if (pay_we) begin
      pay_r[next_r] <= q_head.payload;
    end
  end

  assign empty         = !out_valid_r;
  assign out_item      = out_item_r;
  assign status.busy   = busy_r;
  assign status.count  = count_r;
  assign status.oldest = oldest_r;
  assign status.next   = next_r;

endmodule

`default_nettype wire

// ===== rtl/go_back_n_arq_window_top.sv =====
// ----------------------------------------------------------------------------
// go_back_n_arq_window_top
// Go-back-N sender/receiver window with piggybacked acks and tick timers.
// ----------------------------------------------------------------------------
// The block takes commands through a queue-style input (push/full) and hands
// results out through a queue-style output (empty/pop). A send request gives
// one result: the new frame, or a refusal while seven frames are outstanding.
// A frame arrival gives one arrival report and releases every frame up to the
// piggybacked ack when that ack lies in the window. A tick ages the running
// timers; a tick that hits the timeout gives one result per outstanding frame,
// resent from the oldest, with last set on the final one, and a quiet tick or
// an unknown command gives nothing. The front accepts one request per cycle,
// while the queue has room, into a two-entry operation queue, so the input
// keeps moving while a result waits. The back engine runs one operation at a
// time; a tick that times out then resends the outstanding frames one by one
// through the single result register and takes no new operation until done.
// The timeout register (cfg_we/cfg_data) resets to 150 ticks and is
// clamped to the largest value a TIMER_BITS counter holds; write it only
// while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module go_back_n_arq_window_top
  import gbn_arq_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire in_item_t             in_item,
  output logic                      full,
  output logic                      empty,
  input  wire logic                 pop,
  output out_item_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [TIMEOUT_W-1:0] cfg_data
);

  logic    q_push, q_full, q_empty, q_pop;
  op_t     q_op, q_head;
  status_t status;

  // Decode and drop unknown commands.
  gbn_arq_front u_front (
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_op    (q_op)
  );

  // Hold requests while resending or while sends and arrivals wait on the result register.
  gbn_arq_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_op    (q_op),
    .q_full  (q_full),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_head  (q_head)
  );

  // Run the window and drive the result register.
  gbn_arq_back #(
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .status   (status)
  );

  // The window always spans exactly the outstanding frames.
  a_window_span: assert property (@(posedge clk) disable iff (!rst_n)
    status.next == status.oldest + status.count)
    else $error("window span does not match outstanding count");

  // A resend burst only runs with frames outstanding.
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    status.busy |-> (status.count != '0))
    else $error("resend running with an empty window");

  // A refusal reports a full window.
  a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_item.kind == KIND_REFUSED)) |->
      (out_item.outstanding == SEQ_W'(MAX_SEQ)))
    else $error("send refused with room in the window");

  // An arrival report is always the only result of its request.
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_item.kind == KIND_ARRIVAL)) |-> out_item.last)
    else $error("arrival report without last");

endmodule

`default_nettype wire

// ===== tb/sv/window_checker.sv =====
// ----------------------------------------------------------------------------
// window_checker
// Watches the request, result and timeout-register ports of the go-back-N
// window, predicts each result from its own copy of the window state and
// compares it field by field with what the block returns, in order.
// ----------------------------------------------------------------------------
module window_checker
  import gbn_arq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 full,
  input  in_item_t             in_item,
  input  logic                 pop,
  input  logic                 empty,
  input  out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [TIMEOUT_W-1:0] cfg_data,
  output int                   mismatches,
  output int                   results_waiting,
  output int                   results_seen,
  output int                   resends_seen,
  output int                   refusals_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [SEQ_W-1:0]     oldest;
  logic [SEQ_W-1:0]     next_seq;
  logic [SEQ_W-1:0]     rx_expected;
  logic [SEQ_W-1:0]     in_flight;
  logic                 timer_on     [SEQ_MOD];
  logic [TIMEOUT_W-1:0] timer_age    [SEQ_MOD];
  logic [PAYLOAD_W-1:0] held_payload [SEQ_MOD];
  out_item_t            results_due  [$];

  int errors     = 0;
  int n_results  = 0;
  int n_resends  = 0;
  int n_refusals = 0;

  task automatic clear_window();
    timeout_ticks = TIMEOUT_RESET;
    oldest        = '0;
    next_seq      = '0;
    rx_expected   = '0;
    in_flight     = '0;
    for (int i = 0; i < SEQ_MOD; i++) begin
      timer_on[i]     = 1'b0;
      timer_age[i]    = '0;
      held_payload[i] = '0;
    end
    results_due.delete();
  endtask

  // Circular test: lo <= x < hi modulo the sequence space
  function automatic logic window_holds(input logic [SEQ_W-1:0] lo,
                                        input logic [SEQ_W-1:0] x,
                                        input logic [SEQ_W-1:0] hi);
    return ((lo <= x) && (x < hi)) || ((hi < lo) && (lo <= x)) ||
           ((x < hi) && (hi < lo));
  endfunction

  // Ack carried on outgoing frames: last frame received in order
  function automatic logic [SEQ_W-1:0] ack_now();
    return SEQ_W'(rx_expected + MAX_SEQ);
  endfunction

  function automatic string describe(input out_item_t r);
    return $sformatf("kind %0d seq %0d ack %0d payload %h delivered %0b outstanding %0d last %0b",
                     r.kind, r.tx_seq, r.tx_ack, r.tx_payload, r.delivered,
                     r.outstanding, r.last);
  endfunction

  task automatic queue_result(input logic [KIND_W-1:0]    kind,
                              input logic [SEQ_W-1:0]     seq,
                              input logic [SEQ_W-1:0]     ack,
                              input logic [PAYLOAD_W-1:0] payload,
                              input logic                 delivered,
                              input logic                 last);
    out_item_t r;
    r.kind        = kind;
    r.tx_seq      = seq;
    r.tx_ack      = ack;
    r.tx_payload  = payload;
    r.delivered   = delivered;
    r.outstanding = in_flight;
    r.last        = last;
    results_due.push_back(r);
  endtask

  // Advance the window by one accepted request and queue what it produces
  task automatic apply_request(input in_item_t req);
    logic [SEQ_W-1:0] s;
    logic             expired;
    logic             delivered;
    int               n;
    case (req.cmd)
      CMD_SEND: begin
        if (in_flight >= MAX_SEQ) begin
          queue_result(KIND_REFUSED, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          s               = next_seq;
          held_payload[s] = req.payload_id;
          timer_on[s]     = 1'b1;
          timer_age[s]    = '0;
          in_flight++;
          next_seq        = s + 1'b1;
          queue_result(KIND_SENT, s, ack_now(), held_payload[s], 1'b0, 1'b1);
        end
      end
      CMD_ARRIVE: begin
        delivered = 1'b0;
        if (req.rx_seq == rx_expected) begin
          delivered = 1'b1;
          rx_expected++;
        end
        while (in_flight > 0 && window_holds(oldest, req.rx_ack, next_seq)) begin
          timer_on[oldest]  = 1'b0;
          timer_age[oldest] = '0;
          oldest++;
          in_flight--;
        end
        queue_result(KIND_ARRIVAL, '0, '0, '0, delivered, 1'b1);
      end
      CMD_TICK: begin
        expired = 1'b0;
        for (int i = 0; i < SEQ_MOD; i++) begin
          if (timer_on[i]) begin
            if (timer_age[i] < timeout_ticks) timer_age[i]++;
            if (timer_age[i] >= timeout_ticks) expired = 1'b1;
          end
        end
        // Go back: resend everything outstanding, oldest first
        if (expired && in_flight != 0) begin
          s = oldest;
          for (n = 0; n < in_flight; n++) begin
            timer_on[s]  = 1'b1;
            timer_age[s] = '0;
            queue_result(KIND_RESENT, s, ack_now(), held_payload[s], 1'b0,
                         n + 1 == in_flight);
            s++;
          end
          next_seq = s;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    logic      bad;
    n_results++;
    if (got.kind == KIND_RESENT) n_resends++;
    if (got.kind == KIND_REFUSED) n_refusals++;
    if (results_due.size() == 0) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: unexpected result: %s", $time, describe(got));
      return;
    end
    want = results_due.pop_front();
    bad  = (got.kind !== want.kind) || (got.tx_seq !== want.tx_seq) ||
           (got.tx_ack !== want.tx_ack) || (got.tx_payload !== want.tx_payload) ||
           (got.delivered !== want.delivered) ||
           (got.outstanding !== want.outstanding) || (got.last !== want.last);
    if (bad) begin
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("%0t: result mismatch", $time);
        $display("  expected %s", describe(want));
        $display("  actual   %s", describe(got));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_window();
    end else begin
      if (cfg_we) timeout_ticks = cfg_data;
      if (push && !full) apply_request(in_item);
      if (pop && !empty) check_result(out_item);
    end
    mismatches      <= errors;
    results_waiting <= results_due.size();
    results_seen    <= n_results;
    resends_seen    <= n_resends;
    refusals_seen   <= n_refusals;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the go-back-N window with a directed opening (window fill, refusal,
// acks inside and outside the window, quiet and expiring ticks, zero and
// largest timeouts) and then random request phases under several timeout
// settings, with random gaps on both channels. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gbn_arq_pkg::*;

  // Command code the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 16;   // back engine may still be on a quiet tick
  localparam int TAIL_CYCLES    = 20;
  localparam int STUCK_LIMIT    = 2000; // cycles without any handshake
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_REQUESTS = 80;

  logic                 clk      = 1'b0;
  logic                 rst_n    = 1'b0;
  logic                 push     = 1'b0;
  in_item_t             in_item  = '0;
  logic                 pop      = 1'b0;
  logic                 cfg_we   = 1'b0;
  logic [TIMEOUT_W-1:0] cfg_data = '0;
  logic                 full;
  logic                 empty;
  out_item_t            out_item;

  int mismatches;
  int results_waiting;
  int results_seen;
  int resends_seen;
  int refusals_seen;

  // Stimulus bookkeeping
  int               n_ticks    = 0;
  int               n_sends    = 0;
  int               n_arrivals = 0;
  int               n_unknown  = 0;
  int               n_settings = 0;
  logic [SEQ_W-1:0] peer_seq   = '0; // next in-order seq the block will take
  bit               send_calm  = 1'b0;
  bit               drain_all  = 1'b0;

  always #5 clk = ~clk;

  go_back_n_arq_window_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  window_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_item         (in_item),
    .pop             (pop),
    .empty           (empty),
    .out_item        (out_item),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .results_waiting (results_waiting),
    .results_seen    (results_seen),
    .resends_seen    (resends_seen),
    .refusals_seen   (refusals_seen)
  );

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(15, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic int sender_gap();
    if (send_calm || $urandom_range(0, 99) < 65) return 0;
    return gap_len();
  endfunction

  // Random fields everywhere; callers overwrite the ones that matter
  function automatic in_item_t junk_request(input logic [CMD_W-1:0] cmd);
    in_item_t r;
    r.cmd        = cmd;
    r.payload_id = PAYLOAD_W'($urandom);
    r.rx_seq     = SEQ_W'($urandom);
    r.rx_ack     = SEQ_W'($urandom);
    return r;
  endfunction

  // Receiver: pop with random stalls; calm stretches with no stall at all.
  // Force pop high while draining at the end so stray results surface.
  int pop_gap       = 0;
  int pop_mode_left = 0;
  bit pop_calm      = 1'b0;

  always @(posedge clk) begin
    logic pop_next;
    if (pop_mode_left == 0) begin
      pop_calm      = ($urandom_range(0, 3) == 0);
      pop_mode_left = $urandom_range(50, 300);
    end else begin
      pop_mode_left--;
    end
    if (drain_all) begin
      pop_gap  = 0;
      pop_next = 1'b1;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop_next = 1'b0;
    end else begin
      pop_next = 1'b1;
      if (!pop_calm && $urandom_range(0, 3) == 0) pop_gap = gap_len();
    end
    pop <= pop_next;
  end

  // Watchdog: give up when no request and no result moves for too long
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results still due",
               stuck_cycles, results_waiting);
      $display("testbench: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Offer one request, hold it until accepted, then maybe idle the sender.
  // Keep push high into the next request when there is no gap.
  task automatic issue(input in_item_t req);
    int gap;
    push    <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (full);
    case (req.cmd)
      CMD_TICK:   n_ticks++;
      CMD_SEND:   n_sends++;
      CMD_ARRIVE: begin
        n_arrivals++;
        if (req.rx_seq == peer_seq) peer_seq++;
      end
      default:    n_unknown++;
    endcase
    gap = sender_gap();
    if (gap > 0) begin
      push    <= 1'b0;
      in_item <= junk_request(CMD_W'($urandom));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [PAYLOAD_W-1:0] payload);
    in_item_t r;
    r            = junk_request(CMD_SEND);
    r.payload_id = payload;
    issue(r);
  endtask

  task automatic tick();
    issue(junk_request(CMD_TICK));
  endtask

  task automatic arrive(input logic [SEQ_W-1:0] seq, input logic [SEQ_W-1:0] ack);
    in_item_t r;
    r        = junk_request(CMD_ARRIVE);
    r.rx_seq = seq;
    r.rx_ack = ack;
    issue(r);
  endtask

  task automatic arrive_in_order(input logic [SEQ_W-1:0] ack);
    arrive(peer_seq, ack);
  endtask

  // Hold the sender until every predicted result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
  endtask

  // Write the timeout only with the block idle
  task automatic change_timeout(input logic [TIMEOUT_W-1:0] ticks);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= ticks;
    @(posedge clk);
    cfg_we   <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int                   p;
    int                   r;
    int                   done;
    int                   send_pct;
    int                   tick_pct;
    bit                   drained_mid;
    logic [TIMEOUT_W-1:0] phase_timeout [RANDOM_PHASES];

    phase_timeout    = '{16'd2, 16'hFFFF, 16'd0, 16'd7, 16'd1};
    phase_timeout[3] = TIMEOUT_W'($urandom_range(3, 12));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening under the reset timeout of 150 ticks.
    // Two frames out, then an in-order arrival whose ack lies outside the window.
    send_frame(16'hFFFF);
    send_frame(16'h0000);
    arrive(3'd0, 3'd7);
    // Out-of-order arrival; its ack releases the oldest frame
    arrive(3'd6, 3'd0);
    issue(junk_request(CMD_UNUSED));
    tick();                              // quiet tick
    // Fill the window to seven, then one more send gets refused
    send_frame(16'hA5A5);
    send_frame(16'h5A5A);
    repeat (4) send_frame(PAYLOAD_W'($urandom));
    send_frame(PAYLOAD_W'($urandom));
    arrive_in_order(3'd1);               // release just the oldest frame
    // Timeout of one tick: every tick resends the whole window
    change_timeout(16'd1);
    tick();
    tick();
    arrive_in_order(3'd7);               // release everything up to seq 7
    tick();                              // nothing outstanding, stays quiet
    // Zero timeout: running timers count as expired on each tick
    change_timeout(16'd0);
    send_frame(PAYLOAD_W'($urandom));
    tick();
    tick();
    arrive(SEQ_W'($urandom), 3'd0);
    // Largest timeout: ticks stay quiet
    change_timeout(16'hFFFF);
    send_frame(PAYLOAD_W'($urandom));
    tick();
    arrive_in_order(3'd1);

    // Random phases, one timeout setting each. Arrivals are mostly in order
    // so the receive side keeps delivering; acks land anywhere.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      change_timeout(phase_timeout[p]);
      send_pct    = $urandom_range(30, 50);
      tick_pct    = (phase_timeout[p] == 0) ? $urandom_range(8, 15)
                                            : $urandom_range(15, 35);
      done        = 0;
      drained_mid = 1'b0;
      while (done < PHASE_REQUESTS) begin
        if (done % 30 == 0) send_calm = ($urandom_range(0, 2) == 0);
        if (!drained_mid && done >= PHASE_REQUESTS / 2) begin
          wait_drained();
          drained_mid = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < send_pct) begin
          send_frame(PAYLOAD_W'($urandom));
          done++;
        end else if (r < send_pct + tick_pct) begin
          tick();
          done++;
        end else if (r < 96) begin
          if ($urandom_range(0, 3) == 0) arrive(SEQ_W'($urandom), SEQ_W'($urandom));
          else arrive_in_order(SEQ_W'($urandom));
          done++;
        end else begin
          issue(junk_request(CMD_UNUSED));
        end
      end
    end

    // Drain: pop everything, then allow for anything the block still owes
    drain_all <= 1'b1;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d ticks, %0d sends, %0d arrivals, %0d ignored commands",
             n_ticks, n_sends, n_arrivals, n_unknown);
    $display("summary: %0d timeout writes, %0d results checked, %0d resends, %0d refusals",
             n_settings, results_seen, resends_seen, refusals_seen);
    if (mismatches == 0 && results_waiting == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
